FILE: design/lsrt_pkg.sv
// Shared types, codes and reset constants of the link supervisor.
`default_nettype none

package lsrt_pkg;

  // Event kinds carried in the mode field.
  typedef enum logic [2:0] {
    MODE_UPDATE     = 3'd0,
    MODE_CONNECT    = 3'd1,
    MODE_DISCONNECT = 3'd2,
    MODE_SUBSCRIBE  = 3'd3,
    MODE_RECEIVE    = 3'd4
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SUB_TIMEOUT  = 2'd0,
    CFG_IDLE_TIMEOUT = 2'd1,
    CFG_RSSI_SETTLE  = 2'd2,
    CFG_RSSI_PERIOD  = 2'd3
  } cfg_index_t;

  localparam int unsigned CFG_INDEX_W = 2;

  // Drop causes reported with a drop request.
  localparam logic [1:0] CAUSE_NONE   = 2'd0;
  localparam logic [1:0] CAUSE_NO_SUB = 2'd1;
  localparam logic [1:0] CAUSE_IDLE   = 2'd2;

  // Reset values.
  localparam logic [31:0]        SUB_TIMEOUT_RST  = 32'd30000;
  localparam logic [31:0]        IDLE_TIMEOUT_RST = 32'd30000;
  localparam logic [31:0]        RSSI_SETTLE_RST  = 32'd4000;
  localparam logic [31:0]        RSSI_PERIOD_RST  = 32'd1000;
  localparam logic signed [7:0]  RSSI_AVG_RST     = -8'sd99;
  localparam logic signed [7:0]  RSSI_LOW_RST     = 8'sd0;
  localparam logic signed [7:0]  RSSI_HIGH_RST    = -8'sd127;

  // Reciprocal of ten in 16 fraction bits; exact for magnitudes up to 1280.
  localparam logic [12:0] RECIP_TEN = 13'd6554;

  // One input transaction.
  typedef struct packed {
    logic [2:0]        mode;
    logic [31:0]       now_ms;
    logic [15:0]       sub_value;
    logic signed [7:0] rssi_sample;
    logic              rssi_ok;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic              link_up;
    logic              notify_on;
    logic              link_changed;
    logic              sync_request;
    logic              advertise_start;
    logic              drop_request;
    logic [1:0]        drop_cause;
    logic signed [7:0] rssi_level;
    logic signed [7:0] rssi_floor;
    logic signed [7:0] rssi_peak;
    logic              rssi_updated;
    logic              bounds_changed;
  } result_t;

  // Signal strength tracking state.
  typedef struct packed {
    logic signed [7:0] avg;
    logic signed [7:0] low;
    logic signed [7:0] high;
    logic              valid;
  } rssi_state_t;

endpackage

`default_nettype wire

FILE: design/lsrt_rssi_calc.sv
// Signal strength smoothing filter with floor and peak tracking.
`default_nettype none

module lsrt_rssi_calc
  import lsrt_pkg::*;
(
  input  rssi_state_t       cur,
  input  logic signed [7:0] sample,
  output rssi_state_t       nxt,
  output logic              bounds_changed
);

  logic signed [11:0] avg_ext;
  logic signed [11:0] smp_ext;
  logic signed [11:0] sum;
  logic        [10:0] mag;
  logic        [23:0] prod;
  logic        [7:0]  quot;
  logic signed [7:0]  smoothed;
  logic               new_low;
  logic               new_high;

  // Weighted sum avg*6 + sample*4, which always fits in twelve signed bits.
  always_comb begin
    avg_ext = 12'(cur.avg);
    smp_ext = 12'(sample);
    sum     = (avg_ext <<< 2) + (avg_ext <<< 1) + (smp_ext <<< 2);
  end

  // Divide the magnitude by ten through the reciprocal, then restore the sign,
  // which gives truncation toward zero.
  always_comb begin
    mag      = sum[11] ? 11'(-sum) : sum[10:0];
    prod     = 24'(mag) * 24'(RECIP_TEN);
    quot     = prod[23:16];
    smoothed = sum[11] ? 8'(-quot) : quot;
  end

  // Bounds follow the first sample of a connection, then widen only.
  always_comb begin
    new_low        = !cur.valid || (sample < cur.low);
    new_high       = !cur.valid || (sample > cur.high);
    nxt.low        = new_low  ? sample : cur.low;
    nxt.high       = new_high ? sample : cur.high;
    nxt.avg        = cur.valid ? smoothed : sample;
    nxt.valid      = 1'b1;
    bounds_changed = new_low || new_high;
  end

endmodule

`default_nettype wire

FILE: design/link_supervisor_rssi_tracker.sv
// Link supervisor: connection, subscription, watchdog and signal strength tracking.
// Each accepted transaction passes from the event register to the result register.
// Throughput: one transaction per cycle when not stalled; the event register feeds
// the result register in one pass of timestamp compares and the smoothing filter.
// Reset (rst, synchronous): registers return to their defaults, the link state
// clears and the signal strength returns to its idle values; no clearing pass.
`default_nettype none

module link_supervisor_rssi_tracker
  import lsrt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  // Configuration registers.
  logic [31:0] sub_timeout;
  logic [31:0] idle_timeout;
  logic [31:0] rssi_settle;
  logic [31:0] rssi_period;

  // Event register and result register.
  logic    ev_full;
  item_t   ev;
  logic    advance;

  // Link state.
  logic        connected;
  logic        prev_connected;
  logic        subscribed;
  logic [31:0] connect_time;
  logic [31:0] last_rx_time;
  logic [31:0] last_poll_time;
  rssi_state_t rssi;

  logic        connected_next;
  logic        prev_connected_next;
  logic        subscribed_next;
  logic [31:0] connect_time_next;
  logic [31:0] last_rx_time_next;
  logic [31:0] last_poll_time_next;
  rssi_state_t rssi_next;
  result_t     result_next;

  // Update path helpers.
  logic        link_lost;
  logic        link_gained;
  rssi_state_t rssi_eff;
  rssi_state_t rssi_polled;
  logic        poll_bounds;
  logic [31:0] since_connect;
  logic [31:0] since_rx;
  logic [31:0] since_poll;
  logic        no_sub_expired;
  logic        idle_expired;
  logic        poll_due;

  assign cfg_ready  = 1'b1;
  assign advance    = ev_full && (!result_valid || result_ready);
  assign item_ready = !ev_full || advance;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sub_timeout  <= SUB_TIMEOUT_RST;
      idle_timeout <= IDLE_TIMEOUT_RST;
      rssi_settle  <= RSSI_SETTLE_RST;
      rssi_period  <= RSSI_PERIOD_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SUB_TIMEOUT:  sub_timeout  <= cfg_data;
        CFG_IDLE_TIMEOUT: idle_timeout <= cfg_data;
        CFG_RSSI_SETTLE:  rssi_settle  <= cfg_data;
        CFG_RSSI_PERIOD:  rssi_period  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Event register: takes a new transaction when empty or when the previous one moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_full <= 1'b0;
    end else if (item_ready) begin
      ev_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      ev <= item;
    end
  end

  // Elapsed times, modulo 2^32, and the watchdog and poll decisions.
  always_comb begin
    since_connect  = ev.now_ms - connect_time;
    since_rx       = ev.now_ms - last_rx_time;
    since_poll     = ev.now_ms - last_poll_time;
    no_sub_expired = connected && !subscribed && (since_connect > sub_timeout);
    idle_expired   = connected && subscribed && (since_rx > idle_timeout);
    poll_due       = connected && !no_sub_expired && !idle_expired &&
                     (since_connect >= rssi_settle) && (since_poll >= rssi_period);
  end

  // Link transitions seen by an update, and the tracking state they leave.
  always_comb begin
    link_lost   = !connected && prev_connected;
    link_gained = connected && !prev_connected;
    rssi_eff    = rssi;
    if (link_lost) begin
      rssi_eff.avg = RSSI_AVG_RST;
    end
    if (link_lost || link_gained) begin
      rssi_eff.valid = 1'b0;
      rssi_eff.low   = RSSI_LOW_RST;
      rssi_eff.high  = RSSI_HIGH_RST;
    end
  end

  lsrt_rssi_calc u_rssi_calc (
    .cur            (rssi_eff),
    .sample         (ev.rssi_sample),
    .nxt            (rssi_polled),
    .bounds_changed (poll_bounds)
  );

  // Next state and result for the transaction in the event register.
  always_comb begin
    connected_next      = connected;
    prev_connected_next = prev_connected;
    subscribed_next     = subscribed;
    connect_time_next   = connect_time;
    last_rx_time_next   = last_rx_time;
    last_poll_time_next = last_poll_time;
    rssi_next           = rssi;

    result_next                 = '0;
    result_next.drop_cause      = CAUSE_NONE;

    case (ev.mode)
      MODE_CONNECT: begin
        connected_next           = 1'b1;
        subscribed_next          = 1'b0;
        connect_time_next        = ev.now_ms;
        last_rx_time_next        = ev.now_ms;
        last_poll_time_next      = ev.now_ms;
        result_next.link_changed = 1'b1;
      end
      MODE_DISCONNECT: begin
        connected_next           = 1'b0;
        subscribed_next          = 1'b0;
        result_next.link_changed = 1'b1;
      end
      MODE_SUBSCRIBE: begin
        subscribed_next          = (ev.sub_value != 16'd0);
        result_next.sync_request = !subscribed && (ev.sub_value != 16'd0);
      end
      MODE_RECEIVE: begin
        last_rx_time_next = ev.now_ms;
      end
      MODE_UPDATE: begin
        if (link_lost) begin
          prev_connected_next = 1'b0;
        end
        if (link_gained) begin
          prev_connected_next = 1'b1;
        end
        rssi_next                   = rssi_eff;
        result_next.advertise_start = link_lost;
        if (no_sub_expired) begin
          result_next.drop_request = 1'b1;
          result_next.drop_cause   = CAUSE_NO_SUB;
        end else if (idle_expired) begin
          result_next.drop_request = 1'b1;
          result_next.drop_cause   = CAUSE_IDLE;
        end
        if (poll_due) begin
          last_poll_time_next = ev.now_ms;
          if (ev.rssi_ok) begin
            rssi_next                  = rssi_polled;
            result_next.rssi_updated   = 1'b1;
            result_next.bounds_changed = poll_bounds;
          end
        end
      end
      default: ;
    endcase

    result_next.link_up    = connected_next;
    result_next.notify_on  = subscribed_next;
    result_next.rssi_level = rssi_next.avg;
    result_next.rssi_floor = rssi_next.low;
    result_next.rssi_peak  = rssi_next.high;
  end

  // Link state registers move as each transaction leaves the event register.
  always_ff @(posedge clk) begin
    if (rst) begin
      connected      <= 1'b0;
      prev_connected <= 1'b0;
      subscribed     <= 1'b0;
      connect_time   <= '0;
      last_rx_time   <= '0;
      last_poll_time <= '0;
      rssi.avg       <= RSSI_AVG_RST;
      rssi.low       <= RSSI_LOW_RST;
      rssi.high      <= RSSI_HIGH_RST;
      rssi.valid     <= 1'b0;
    end else if (advance) begin
      connected      <= connected_next;
      prev_connected <= prev_connected_next;
      subscribed     <= subscribed_next;
      connect_time   <= connect_time_next;
      last_rx_time   <= last_rx_time_next;
      last_poll_time <= last_poll_time_next;
      rssi           <= rssi_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/lsrt_checker.sv
// Port-level checks of the link supervisor, bound to the top level.
`default_nettype none

module lsrt_checker
  import lsrt_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   result_valid,
  input logic                   result_ready,
  input result_t                result
);

  // A stalled result transaction stays on the port unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // A cause is reported exactly when a drop is requested.
  a_cause_match: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.drop_request == (result.drop_cause != CAUSE_NONE)))
    else $error("drop cause does not match drop request");

  // Each event kind raises its own pulses only, and a drop excludes a poll.
  a_pulses_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot0({result.link_changed, result.sync_request,
                               result.advertise_start, result.drop_request,
                               result.rssi_updated}))
    else $error("more than one event pulse in a result");

  // The bounds-changed flag is only raised on a valid sample taken while connected.
  a_bounds_on_poll: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.bounds_changed |-> result.rssi_updated && result.link_up)
    else $error("bounds changed without a poll on a live link");

  // A synchronisation request always leaves the client subscribed.
  a_sync_subscribed: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.sync_request |-> result.notify_on && !result.link_changed)
    else $error("sync request without subscription");

endmodule

bind link_supervisor_rssi_tracker lsrt_checker u_lsrt_checker (.*);

`default_nettype wire
